[hw/rtl/ais_pkg.sv]
// Shared types and constants for the ascending integer sorter.
`timescale 1ns / 1ps

package ais_pkg;

    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 64;

    typedef logic signed [DATA_W-1:0] data_t;

endpackage

[hw/rtl/ascending_integer_sorter.sv]
// Top level of the ascending integer sorter: store, bubble sequencer, result emit.
`timescale 1ns / 1ps

// Channel  Handshake                 Payload
// -------  ------------------------  ----------------------------------------
// value    value_valid/value_stall   value[31:0] signed, final_item
// result   result_valid/result_stall sorted_value[31:0] signed, run_end, overflowed
//
// Loading accepts one item per cycle; the set ends on the item with final_item set.
// Sorting runs bubble passes through the one compare-exchange unit and the single
// read / single write port of the store: at most n-1 passes for n values,
// stopping on a pass without swaps.
// Each result is read, loaded and then held while result_stall is high.
// value_stall is high from the final item until the last result is taken.
// Reset clears control state only; the store needs no clearing pass.

module ascending_integer_sorter
    import ais_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        value_valid,
    output logic        value_stall,
    input  data_t       value,
    input  logic        final_item,
    output logic        result_valid,
    input  logic        result_stall,
    output data_t       sorted_value,
    output logic        run_end,
    output logic        overflowed
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_START   = 3'd1;  // read entry 0 of a pass
    localparam logic [2:0] S_LOAD0   = 3'd2;  // entry 0 becomes the carry
    localparam logic [2:0] S_CMP     = 3'd3;  // compare carry with entry j
    localparam logic [2:0] S_WB      = 3'd4;  // carry lands at the pass top
    localparam logic [2:0] S_EMIT_RD = 3'd5;
    localparam logic [2:0] S_EMIT_LD = 3'd6;
    localparam logic [2:0] S_EMIT_HD = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              overflow_reg, overflow_next;
    logic [ADDR_W-1:0] pass_last_reg, pass_last_next;
    logic [ADDR_W-1:0] last_idx_reg, last_idx_next;
    logic [ADDR_W-1:0] j_reg, j_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic              swapped_reg, swapped_next;
    data_t             carry_reg, carry_next;

    logic              out_valid_reg, out_valid_next;
    data_t             out_value_reg, out_value_next;
    logic              out_end_reg, out_end_next;
    logic              out_ovf_reg, out_ovf_next;

    // value store: one write port, one registered read port
    data_t             mem [CAPACITY];
    data_t             rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    data_t             wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // compare-exchange unit, shared by every step of every pass
    data_t cu_lo, cu_hi;
    logic  cu_swap;

    ais_cmp_swap u_cmp (
        .a    (carry_reg),
        .b    (rd_data_reg),
        .lo   (cu_lo),
        .hi   (cu_hi),
        .swap (cu_swap)
    );

    logic in_acc;
    logic has_room;
    logic [ADDR_W-1:0] set_last;

    assign value_stall = (state_reg != S_IDLE);
    assign in_acc      = value_valid && !value_stall;
    assign has_room    = (count_reg < CNT_W'(CAPACITY));
    // index of the last value held once this item is in
    assign set_last    = has_room ? count_reg[ADDR_W-1:0] : ADDR_W'(CAPACITY - 1);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        overflow_next  = overflow_reg;
        pass_last_next = pass_last_reg;
        last_idx_next  = last_idx_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        swapped_next   = swapped_reg;
        carry_next     = carry_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_end_next   = out_end_reg;
        out_ovf_next   = out_ovf_reg;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = count_reg[ADDR_W-1:0];
        wr_data        = value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (has_room)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (final_item)
                    begin
                        pass_last_next = set_last;
                        last_idx_next  = set_last;
                        k_next         = '0;
                        state_next     = (set_last == '0) ? S_EMIT_RD : S_START;
                    end
                end
            end
            S_START:
            begin
                rd_addr      = '0;
                swapped_next = 1'b0;
                state_next   = S_LOAD0;
            end
            S_LOAD0:
            begin
                rd_addr    = ADDR_W'(1);
                carry_next = rd_data_reg;
                j_next     = ADDR_W'(1);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                rd_addr      = j_reg + ADDR_W'(1);
                wr_en        = 1'b1;
                wr_addr      = j_reg - ADDR_W'(1);
                wr_data      = cu_lo;
                carry_next   = cu_hi;
                swapped_next = swapped_reg | cu_swap;
                if (j_reg == pass_last_reg)
                begin
                    state_next = S_WB;
                end
                else
                begin
                    j_next = j_reg + ADDR_W'(1);
                end
            end
            S_WB:
            begin
                wr_en          = 1'b1;
                wr_addr        = pass_last_reg;
                wr_data        = carry_reg;
                pass_last_next = pass_last_reg - ADDR_W'(1);
                // no swap, or only one entry left below: sorted
                if (!swapped_reg || pass_last_reg == ADDR_W'(1))
                begin
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    state_next = S_START;
                end
            end
            S_EMIT_RD:
            begin
                rd_addr    = k_reg;
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                out_valid_next = 1'b1;
                out_value_next = rd_data_reg;
                out_end_next   = (k_reg == last_idx_reg);
                out_ovf_next   = overflow_reg;
                state_next     = S_EMIT_HD;
            end
            S_EMIT_HD:
            begin
                if (!result_stall)
                begin
                    out_valid_next = 1'b0;
                    if (out_end_reg)
                    begin
                        count_next    = '0;
                        overflow_next = 1'b0;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + ADDR_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pass_last_reg <= pass_last_next;
        last_idx_reg  <= last_idx_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        swapped_reg   <= swapped_next;
        carry_reg     <= carry_next;
        out_value_reg <= out_value_next;
        out_end_reg   <= out_end_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign result_valid = out_valid_reg;
    assign sorted_value = out_value_reg;
    assign run_end      = out_end_reg;
    assign overflowed   = out_ovf_reg;

    // a result is only shown while the emit step holds it
    a_valid_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (state_reg == S_EMIT_HD))
        else $error("result_valid outside emit hold");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("stored count beyond capacity");

    a_cmp_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (j_reg != '0 && j_reg <= pass_last_reg))
        else $error("compare index outside pass");

    a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && run_end)
            |=> (count_reg == '0 && !overflow_reg && state_reg == S_IDLE))
        else $error("set not cleared after run end");

    a_end_index: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && run_end) |-> (k_reg == last_idx_reg))
        else $error("run end on wrong entry");

endmodule

[hw/rtl/ais_cmp_swap.sv]
// Shared compare-exchange unit: orders two signed values.
`timescale 1ns / 1ps

module ais_cmp_swap
    import ais_pkg::*;
(
    input  data_t a,
    input  data_t b,
    output data_t lo,
    output data_t hi,
    output logic  swap
);

    // swap set when a is strictly greater; ties keep their order
    assign swap = (a > b);
    assign lo   = swap ? b : a;
    assign hi   = swap ? a : b;

endmodule

[sim/ascending_integer_sorter_tb.sv]
// Testbench for the ascending integer sorter: directed and random sets in bursts, random stalls out, scoreboard.
`timescale 1ns / 1ps

module ascending_integer_sorter_tb;

    import ais_pkg::*;

    localparam int SORT_DEPTH  = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 210;

    // One expected result of a sorted run.
    typedef struct packed {
        data_t v;
        logic  last;
        logic  ovf;
    } run_entry_t;

    // Collects the current set and predicts its sorted run when the final item lands.
    class sort_scoreboard;
        data_t       held[$];
        bit          dropped;
        int unsigned depth;
        run_entry_t  due[$];
        int          errors;

        function new(int unsigned d);
            depth   = d;
            dropped = 0;
            errors  = 0;
        endfunction

        function void note_value(data_t v, logic fin);
            data_t      key;
            int         j;
            run_entry_t e;
            if (held.size() < depth)
                held.push_back(v);
            else
                dropped = 1;
            if (!fin)
                return;
            // insertion sort, signed ascending
            for (int i = 1; i < held.size(); i++)
            begin
                key = held[i];
                j   = i - 1;
                while (j >= 0 && held[j] > key)
                begin
                    held[j+1] = held[j];
                    j--;
                end
                held[j+1] = key;
            end
            foreach (held[k])
            begin
                e.v    = held[k];
                e.last = (k == held.size() - 1);
                e.ovf  = dropped;
                due.push_back(e);
            end
            held.delete();
            dropped = 0;
        endfunction

        function void check_result(data_t v, logic last, logic ovf);
            run_entry_t e;
            if (due.size() == 0)
            begin
                $error("unexpected result: sorted_value %0d", v);
                errors++;
                return;
            end
            e = due.pop_front();
            if (v !== e.v)
            begin
                $error("sorted_value: expected %0d, got %0d", e.v, v);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("run_end: expected %0b, got %0b", e.last, last);
                errors++;
            end
            if (ovf !== e.ovf)
            begin
                $error("overflowed: expected %0b, got %0b", e.ovf, ovf);
                errors++;
            end
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  value_valid;
    logic  value_stall;
    data_t value;
    logic  final_item;
    logic  result_valid;
    logic  result_stall;
    data_t sorted_value;
    logic  run_end;
    logic  overflowed;

    int unsigned    cycle_count = 0;
    int             burst_left  = 0;
    int             stall_mode  = 0;
    int             stall_left  = 0;
    sort_scoreboard sb = new(SORT_DEPTH);

    ascending_integer_sorter #(
        .CAPACITY (SORT_DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .value_valid  (value_valid),
        .value_stall  (value_stall),
        .value        (value),
        .final_item   (final_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sorted_value (sorted_value),
        .run_end      (run_end),
        .overflowed   (overflowed)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("ascending_integer_sorter test failed");
        $finish;
    end

    // Result side: check accepted items, then pick the next stall level.
    // Modes: never stall, light, heavy, and long stall stretches.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(sorted_value, run_end, overflowed);
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 150);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 3) == 0);
            2:       result_stall <= ($urandom_range(0, 3) != 0);
            default: result_stall <= ($urandom_range(0, 15) < 14);
        endcase
    end

    // Mostly full-range values, with extremes and a narrow band for duplicates.
    function automatic data_t pick_value();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(DATA_W-1){1'b0}}};
            1:       return {1'b0, {(DATA_W-1){1'b1}}};
            2:       return $urandom_range(0, 1) ? data_t'(0) : data_t'(-1);
            3, 4:    return data_t'(int'($urandom_range(0, 8)) - 4);
            default: return data_t'($urandom);
        endcase
    endfunction

    // Holds the item until taken, then maybe opens a gap before the next one.
    task automatic send_item(data_t v, logic fin);
        value       <= v;
        final_item  <= fin;
        value_valid <= 1'b1;
        do
            @(posedge clk);
        while (value_stall);
        sb.note_value(v, fin);
        if (burst_left == 0)
        begin
            value_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(0, 30);
        end
        else
            burst_left--;
    endtask

    task automatic send_set(data_t vals[$]);
        foreach (vals[i])
            send_item(vals[i], i == vals.size() - 1);
    endtask

    initial
    begin
        int    sent;
        int    set_idx;
        int    set_len;
        data_t mn;
        data_t mx;

        mn = {1'b1, {(DATA_W-1){1'b0}}};
        mx = {1'b0, {(DATA_W-1){1'b1}}};

        rst_n        = 1'b0;
        value_valid  = 1'b0;
        value        = '0;
        final_item   = 1'b0;
        result_stall = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: one-value set, extremes, ties, sorted and reversed input
        send_set('{data_t'(5)});
        send_set('{mx, mn, data_t'(0), data_t'(-1), data_t'(1)});
        send_set('{data_t'(3), data_t'(3), data_t'(-3), data_t'(3), data_t'(-3)});
        send_set('{data_t'(-2), data_t'(-1), data_t'(0), data_t'(1), data_t'(2)});
        send_set('{data_t'(4), data_t'(3), data_t'(2), data_t'(1), data_t'(0), mn});
        send_set('{mx, mx});

        // random sets; a few exercise a full store and dropped items,
        // including a dropped final item
        sent    = 0;
        set_idx = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case (set_idx)
                1:       set_len = SORT_DEPTH;
                3:       set_len = SORT_DEPTH + 1;
                5:       set_len = SORT_DEPTH + $urandom_range(2, 6);
                default: set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                               : $urandom_range(1, 12);
            endcase
            for (int i = 0; i < set_len; i++)
                send_item(pick_value(), i == set_len - 1);
            sent += set_len;
            set_idx++;
        end
        value_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("ascending_integer_sorter test passed");
        else
            $display("ascending_integer_sorter test failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/ais_pkg.sv
hw/rtl/ais_cmp_swap.sv
hw/rtl/ascending_integer_sorter.sv
sim/ascending_integer_sorter_tb.sv
